### rtl/ms_pkg.sv
`default_nettype none

package ms_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int VALUE_W       = 32;

    typedef logic signed [VALUE_W-1:0] value_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic insert;     // place the broadcast value into the ordered row
        logic shift_out;  // move every entry one cell toward the head
    } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/ms_in_if.sv
`default_nettype none

interface ms_in_if
    import ms_pkg::*;
;
    logic   valid;
    logic   ready;
    value_t value;
    logic   final_item;

    modport source (output valid, output value, output final_item, input ready);
    modport sink   (input valid, input value, input final_item, output ready);
endinterface

`default_nettype wire

### rtl/ms_out_if.sv
`default_nettype none

interface ms_out_if
    import ms_pkg::*;
;
    logic   valid;
    logic   ready;
    value_t sorted_value;
    logic   end_of_run;
    logic   dropped;

    modport source (output valid, output sorted_value, output end_of_run, output dropped,
                    input ready);
    modport sink   (input valid, input sorted_value, input end_of_run, input dropped,
                    output ready);
endinterface

`default_nettype wire

### rtl/merge_sorter.sv
`default_nettype none

// Batch sorter for signed 32-bit values. Requests are loaded one per cycle, while no batch
// drains, into a row of MAX_ITEMS compare-and-shift cells that keeps them in ascending
// order as they arrive; equal values keep their arrival order. The request marked final_item
// ends the batch: the block then stops taking input and streams the sorted values from the
// head cell, one per cycle while the sink is ready, with end_of_run on the last one.
// Requests beyond MAX_ITEMS are discarded and set dropped on every result of that batch (a
// discarded final request still ends the batch). A batch is fully loaded through the single
// insert port of the cell row before it drains through the single output port.
module merge_sorter
    import ms_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    ms_in_if.sink     in_ch,
    ms_out_if.source  out_ch
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    typedef enum logic { LOAD, DRAIN } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             overflow_reg;
    logic             overflow_next;

    cell_ctrl_t ctrl;
    logic       in_fire;
    logic       out_fire;
    logic       has_room;

    logic       cell_take  [MAX_ITEMS];
    logic       cell_valid [MAX_ITEMS];
    value_t     cell_value [MAX_ITEMS];

    assign in_ch.ready  = (state_reg == LOAD);
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign out_fire     = out_ch.valid && out_ch.ready;
    assign has_room     = (count_reg < CNT_W'(MAX_ITEMS));

    assign ctrl.insert    = in_fire && has_room;
    assign ctrl.shift_out = out_fire;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++)
        begin : g_cell
            logic   l_take;
            logic   l_valid;
            value_t l_value;
            logic   r_valid;
            value_t r_value;

            if (gi == 0)
            begin : g_head
                assign l_take  = 1'b0;
                assign l_valid = 1'b0;
                assign l_value = '0;
            end
            else
            begin : g_body
                assign l_take  = cell_take[gi-1];
                assign l_valid = cell_valid[gi-1];
                assign l_value = cell_value[gi-1];
            end

            if (gi == MAX_ITEMS - 1)
            begin : g_tail
                assign r_valid = 1'b0;
                assign r_value = '0;
            end
            else
            begin : g_mid
                assign r_valid = cell_valid[gi+1];
                assign r_value = cell_value[gi+1];
            end

            ms_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .new_value   (in_ch.value),
                .left_take   (l_take),
                .left_valid  (l_valid),
                .left_value  (l_value),
                .right_valid (r_valid),
                .right_value (r_value),
                .take        (cell_take[gi]),
                .valid       (cell_valid[gi]),
                .value       (cell_value[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        unique case (state_reg)
            LOAD:
            begin
                if (in_fire)
                begin
                    if (has_room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (in_ch.final_item)
                    begin
                        state_next = DRAIN;
                    end
                end
            end
            DRAIN:
            begin
                if (out_fire)
                begin
                    count_next = count_reg - CNT_W'(1);
                    // last result taken: start a fresh batch
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next    = LOAD;
                        overflow_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= LOAD;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    assign out_ch.valid        = (state_reg == DRAIN);
    assign out_ch.sorted_value = cell_value[0];
    assign out_ch.end_of_run   = (count_reg == CNT_W'(1));
    assign out_ch.dropped      = overflow_reg;

    // the head cell holds data exactly when the batch is not empty
    a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) == cell_valid[0])
        else $error("head cell occupancy disagrees with item count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("item count exceeds capacity");

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DRAIN) |-> (count_reg != '0))
        else $error("draining an empty row");

    a_last_returns_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && out_ch.end_of_run) |=> (in_ch.ready && (count_reg == '0) && !overflow_reg))
        else $error("batch state not cleared after last result");

endmodule

`default_nettype wire

### rtl/ms_cell.sv
`default_nettype none

module ms_cell
    import ms_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire value_t     new_value,
    input  wire logic       left_take,
    input  wire logic       left_valid,
    input  wire value_t     left_value,
    input  wire logic       right_valid,
    input  wire value_t     right_value,
    output      logic       take,
    output      logic       valid,
    output      value_t     value
);

    logic   valid_reg;
    logic   valid_next;
    value_t value_reg;
    value_t value_next;

    // an empty cell counts as larger than anything; ties stay ahead of the new value
    assign take = !valid_reg || (value_reg > new_value);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.shift_out)
        begin
            valid_next = right_valid;
            value_next = right_value;
        end
        else if (ctrl.insert && take)
        begin
            if (left_take)
            begin
                valid_next = left_valid;
                value_next = left_value;
            end
            else
            begin
                valid_next = 1'b1;
                value_next = new_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;

endmodule

`default_nettype wire

### tb/sv/sort_checker.sv
`default_nettype none

module sort_checker
    import ms_pkg::*;
#(
    parameter int CAPACITY = MAX_ITEMS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    ms_in_if          in_mon,
    ms_out_if         out_mon,
    output int        fail_count,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        value_t sorted_value;
        logic   end_of_run;
        logic   dropped;
    } sorted_rec_t;

    value_t      batch_values[$];
    logic        batch_overflow;
    sorted_rec_t sorted_due[$];
    int          errors;

    // Stable insertion sort of the held batch, then queue one result per entry.
    function automatic void emit_sorted_batch();
        value_t      key;
        int          j;
        sorted_rec_t rec;
        for (int i = 1; i < batch_values.size(); i++)
        begin
            key = batch_values[i];
            j = i - 1;
            // strict compare keeps equal values in arrival order
            while (j >= 0 && batch_values[j] > key)
            begin
                batch_values[j + 1] = batch_values[j];
                j--;
            end
            batch_values[j + 1] = key;
        end
        for (int k = 0; k < batch_values.size(); k++)
        begin
            rec.sorted_value = batch_values[k];
            rec.end_of_run   = (k == batch_values.size() - 1);
            rec.dropped      = batch_overflow;
            sorted_due.push_back(rec);
        end
        batch_values.delete();
        batch_overflow = 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        sorted_rec_t due;
        if (!rst_n)
        begin
            batch_values.delete();
            sorted_due.delete();
            batch_overflow = 1'b0;
            errors = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                if (sorted_due.size() == 0)
                begin
                    $error("unexpected result: sorted_value %0d end_of_run %0b dropped %0b",
                           out_mon.sorted_value, out_mon.end_of_run, out_mon.dropped);
                    errors++;
                end
                else
                begin
                    due = sorted_due.pop_front();
                    if (out_mon.sorted_value !== due.sorted_value)
                    begin
                        $error("sorted_value: expected %0d, got %0d",
                               due.sorted_value, out_mon.sorted_value);
                        errors++;
                    end
                    if (out_mon.end_of_run !== due.end_of_run)
                    begin
                        $error("end_of_run: expected %0b, got %0b",
                               due.end_of_run, out_mon.end_of_run);
                        errors++;
                    end
                    if (out_mon.dropped !== due.dropped)
                    begin
                        $error("dropped: expected %0b, got %0b",
                               due.dropped, out_mon.dropped);
                        errors++;
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                if (batch_values.size() < CAPACITY)
                    batch_values.push_back(in_mon.value);
                else
                    batch_overflow = 1'b1;
                // a discarded final request still closes the batch
                if (in_mon.final_item)
                    emit_sorted_batch();
            end
            fail_count <= errors;
            pending <= sorted_due.size();
        end
    end

endmodule

`default_nettype wire

### tb/sv/merge_sorter_test.sv
`default_nettype none

module merge_sorter_test
    import ms_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = MAX_ITEMS_DEF;
    localparam int RANDOM_ITEMS = 460;
    localparam int DRAIN_CYCLES = 4 * CAPACITY;
    // ~500 requests and results, each behind a random stall, plus the load and drain
    // of every item in the block, with a wide margin
    localparam int CYCLE_LIMIT  = 600000;

    typedef enum int {VAL_WIDE, VAL_CLUSTER, VAL_EDGE, VAL_MIXED} value_mix_t;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;

    ms_in_if  in_ch();
    ms_out_if out_ch();

    merge_sorter DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    sort_checker #(.CAPACITY(CAPACITY)) scoreboard
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (in_ch),
        .out_mon    (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 40);
    endfunction

    function automatic value_t pick_value(input value_mix_t mix);
        value_mix_t sel;
        sel = (mix == VAL_MIXED) ? value_mix_t'($urandom_range(0, 2)) : mix;
        case (sel)
            VAL_CLUSTER: return value_t'($urandom_range(0, 8)) - value_t'(4);
            VAL_EDGE:
            begin
                case ($urandom_range(0, 4))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7fff_ffff;
                    2:       return '0;
                    3:       return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            default:     return value_t'($urandom);
        endcase
    endfunction

    task automatic send_request(input value_t v, input logic fin, input bit steady);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.value      <= v;
        in_ch.final_item <= fin;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic send_batch(input int n, input value_mix_t mix, input bit steady);
        for (int i = 0; i < n; i++)
            send_request(pick_value(mix), i == n - 1, steady);
    endtask

    // result side: hold ready low for random stalls, with occasional long clean runs
    initial
    begin : sink_side
        int stall;
        int run;
        out_ch.ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                stall = 0;
                run = 200;
            end
            else
            begin
                stall = pick_gap();
                run = $urandom_range(1, 24);
            end
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            repeat (run) @(posedge clk);
        end
    end

    initial
    begin : source_side
        int stored;
        int batch_idx;
        int size;
        int r;
        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.value      <= '0;
        in_ch.final_item <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-entry batches at both extremes
        send_request(32'sh7fff_ffff, 1'b1, 1'b0);
        send_request(32'sh8000_0000, 1'b1, 1'b0);
        // extremes, zero, minus one and repeated values in one batch
        send_request('0,             1'b0, 1'b1);
        send_request(-32'sd1,        1'b0, 1'b1);
        send_request(32'sh7fff_ffff, 1'b0, 1'b1);
        send_request(32'sh8000_0000, 1'b0, 1'b1);
        send_request(32'sd5,         1'b0, 1'b0);
        send_request(32'sd5,         1'b0, 1'b0);
        send_request(-32'sd5,        1'b0, 1'b0);
        send_request(32'sd1,         1'b0, 1'b0);
        send_request(32'sh8000_0000, 1'b0, 1'b0);
        send_request(32'sh7fff_ffff, 1'b1, 1'b0);
        // reversed order
        send_request(32'sd3,         1'b0, 1'b0);
        send_request(32'sd2,         1'b0, 1'b0);
        send_request(32'sd1,         1'b0, 1'b0);
        send_request('0,             1'b1, 1'b0);
        // already ascending
        send_request(-32'sd7,        1'b0, 1'b1);
        send_request(32'sd0,         1'b0, 1'b1);
        send_request(32'sd7,         1'b1, 1'b1);

        // open with a batch that fills the store exactly and one whose final is dropped
        stored = 0;
        batch_idx = 0;
        while (stored < RANDOM_ITEMS)
        begin
            if (batch_idx == 0)
                size = CAPACITY;
            else if (batch_idx == 1)
                size = CAPACITY + 1;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    size = $urandom_range(1, 12);
                else if (r < 92)
                    size = $urandom_range(13, 40);
                else
                    size = $urandom_range(CAPACITY - 2, CAPACITY + 10);
            end
            send_batch(size, value_mix_t'($urandom_range(0, 3)), $urandom_range(0, 3) == 0);
            stored += (size < CAPACITY) ? size : CAPACITY;
            batch_idx++;
        end
        in_ch.valid <= 1'b0;

        // let the checker register the last final request before polling
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
